@@ hw/rtl/rpdf_pkg.sv @@
`default_nettype none

package rpdf_pkg;

   localparam int ID_W       = 16;
   localparam int OFF_W      = 16;
   localparam int REQ_DATA_W = 32;
   localparam int CNT_OUT_W  = 5;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic [OFF_W-1:0] frag_offset;
      logic [ID_W-1:0]  ident;
   } key_type;

   typedef struct packed {
      key_type key;
      logic    ident_only;
      logic    wr_en;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/rpdf_cell.sv @@
`default_nettype none

module rpdf_cell #(
   parameter int DEPTH = 32,
   parameter int SLOT  = 0
) (
   input  wire logic                                     clock,
   input  wire rpdf_pkg::cell_ctl_type                   ctl,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_slot,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] newest,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] held,
   input  wire logic                                     hit_in,
   output logic                                          hit_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] SLOT_IDX  = AW'(SLOT);
   localparam logic [AW:0]   WRAP_DIST = (AW+1)'(DEPTH - SLOT);

   logic [rpdf_pkg::ID_W-1:0]  ident_ff;
   logic [rpdf_pkg::OFF_W-1:0] offset_ff;
   logic                       hit_ff;
   logic [AW-1:0]              slot_age;
   logic [AW:0]                dist_wrap;
   logic                       slot_valid;
   logic                       key_match;

   // distance back from the newest slot; the slot is held if it lies within the count
   always_comb begin
      dist_wrap = {1'b0, newest} + WRAP_DIST;
      if (newest >= SLOT_IDX) begin
         slot_age = newest - SLOT_IDX;
      end else begin
         slot_age = dist_wrap[AW-1:0];
      end
      slot_valid = (slot_age < held);
      key_match  = (ident_ff == ctl.key.ident) &&
                   (ctl.ident_only || (offset_ff == ctl.key.frag_offset));
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && (wr_slot == SLOT_IDX)) begin
         ident_ff <= ctl.key.ident;
         if (!ctl.ident_only) begin
            offset_ff <= ctl.key.frag_offset;
         end
      end
      hit_ff <= hit_in | (slot_valid & key_match);
   end

   assign hit_out = hit_ff;

endmodule

`default_nettype wire

@@ hw/rtl/recent_packet_duplicate_filter.sv @@
// One item at a time: req_tready is high only in the idle state, so a new item is taken
// only after the last one's response is registered, which waits while rsp_tready is low.
// The match flag ripples one cell per cycle down the HISTORY_DEPTH cells of the history chain.
// Reset (synchronous): clears pointers, count, mode register, control and rsp_tvalid;
// key storage is not cleared and no clearing pass runs.
`default_nettype none

module recent_packet_duplicate_filter #(
   parameter int HISTORY_DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rpdf_pkg::REQ_DATA_W-1:0]   req_tdata,   // ident[15:0], frag_offset[31:16]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rpdf_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // entries_held[4:0], zero[7:5]
   output logic                                   rsp_tuser,   // is_duplicate[0]
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic                              csr_data     // ident_only_mode[0]
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = (AW > rpdf_pkg::CNT_OUT_W) ? AW : rpdf_pkg::CNT_OUT_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [AW-1:0]                    cnt_ff, cnt_in;
   rpdf_pkg::key_type                key_ff, key_in;
   logic [AW-1:0]                    newest_ff, newest_in;
   logic [AW-1:0]                    oldest_ff, oldest_in;
   logic [AW-1:0]                    held_ff, held_in;
   logic                             mode_ff, mode_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_dup_ff, rsp_dup_in;
   logic [rpdf_pkg::CNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [AW-1:0]                    target;
   logic [AW-1:0]                    oldest_next;
   logic                             done_go;
   logic                             insert;
   logic [CW-1:0]                    held_ext;
   logic [HISTORY_DEPTH:0]           hit_chain;
   rpdf_pkg::cell_ctl_type           cell_ctl;
   logic [AW-1:0]                    ptr_gap;
   logic [AW:0]                      ptr_gap_wrap;

   assign target      = (newest_ff == LAST_SLOT) ? '0 : newest_ff + 1'b1;
   assign oldest_next = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
   assign done_go     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign insert      = done_go && !hit_chain[HISTORY_DEPTH];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_count_in = rsp_count_ff;
      mode_in      = csr_valid ? csr_data : mode_ff;
      held_ext     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in   = rpdf_pkg::key_type'(req_tdata);
               cnt_in   = LAST_SLOT;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               // append on a miss, evicting the oldest when full
               if (insert) begin
                  newest_in = target;
                  if (target == oldest_ff) begin
                     oldest_in = oldest_next;
                  end else begin
                     held_in = held_ff + 1'b1;
                  end
               end
               held_ext     = CW'(held_in);
               rsp_valid_in = 1'b1;
               rsp_dup_in   = hit_chain[HISTORY_DEPTH];
               rsp_count_in = held_ext[rpdf_pkg::CNT_OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         held_ff      <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign cell_ctl.key        = key_ff;
   assign cell_ctl.ident_only = mode_ff;
   assign cell_ctl.wr_en      = insert;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      rpdf_cell #(
         .DEPTH (HISTORY_DEPTH),
         .SLOT  (i)
      ) u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .wr_slot (target),
         .newest  (newest_ff),
         .held    (held_ff),
         .hit_in  (hit_chain[i]),
         .hit_out (hit_chain[i+1])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_dup_ff;
   assign rsp_tdata  = rpdf_pkg::RSP_DATA_W'(rsp_count_ff);
   assign csr_ready  = 1'b1;

   assign ptr_gap_wrap = {1'b0, newest_ff} + DEPTH_EXT - {1'b0, oldest_ff};
   assign ptr_gap      = (newest_ff >= oldest_ff) ? newest_ff - oldest_ff
                                                  : ptr_gap_wrap[AW-1:0];

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= LAST_SLOT)
      else $error("history count exceeds capacity");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      ptr_gap == held_ff)
      else $error("ring pointers disagree with history count");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   a_hold_on_dup: assert property (@(posedge clock) disable iff (reset)
      (done_go && hit_chain[HISTORY_DEPTH]) |=>
         ($stable(newest_ff) && $stable(held_ff) && $stable(oldest_ff)))
      else $error("history changed on a duplicate");

endmodule

`default_nettype wire

@@ bench/recent_packet_duplicate_filter_tb.sv @@
`default_nettype none

module recent_packet_duplicate_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 32;
   localparam int LIMIT_CYCLES = 800000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = DEPTH + 8;

   typedef enum int {PRESS_NONE, PRESS_RX_HOLD, PRESS_TX_PAUSE} pressure_e;

   typedef struct {
      logic       dup;
      logic [4:0] held;
   } verdict_t;

   class dup_history_scoreboard;
      logic [15:0] ident_q[DEPTH];
      logic [15:0] offset_q[DEPTH];
      bit          offset_known[DEPTH];
      int          newest;
      int          oldest;
      int          held;
      bit          ident_only;
      int          errors;
      verdict_t    verdicts[$];

      function new();
         newest = 0;
         oldest = 0;
         held = 0;
         ident_only = 0;
         errors = 0;
         foreach (offset_known[i]) offset_known[i] = 0;
      endfunction

      function void set_mode(bit m);
         ident_only = m;
      endfunction

      function void note_request(logic [15:0] id, logic [15:0] off);
         verdict_t v;
         int slot;
         bit dup;
         dup = 0;
         slot = newest;
         for (int n = 0; n < held; n++) begin
            if (ident_q[slot] == id && (ident_only || offset_q[slot] == off)) begin
               dup = 1;
               break;
            end
            slot = (slot + DEPTH - 1) % DEPTH;
         end
         if (!dup) begin
            slot = (newest + 1) % DEPTH;
            if (slot == oldest) oldest = (oldest + 1) % DEPTH;
            else held++;
            newest = slot;
            ident_q[slot] = id;
            if (!ident_only) begin
               offset_q[slot] = off;
               offset_known[slot] = 1;
            end
         end
         v.dup = dup;
         v.held = 5'(held);
         verdicts.push_back(v);
      endfunction

      function void check_response(logic dup, logic [4:0] held_out);
         verdict_t v;
         if (verdicts.size() == 0) begin
            $error("unexpected item: is_duplicate %0d entries_held %0d", dup, held_out);
            errors++;
            return;
         end
         v = verdicts.pop_front();
         if (dup !== v.dup) begin
            $error("is_duplicate: expected %0d, actual %0d", v.dup, dup);
            errors++;
         end
         if (held_out !== v.held) begin
            $error("entries_held: expected %0d, actual %0d", v.held, held_out);
            errors++;
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction

      function bit offsets_ready();
         foreach (offset_known[i]) if (!offset_known[i]) return 0;
         return 1;
      endfunction

      function logic [31:0] held_key(int back);
         int slot;
         slot = (newest - back + DEPTH) % DEPTH;
         return {offset_q[slot], ident_q[slot]};
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [31:0] req_tdata = '0;   // ident[15:0], frag_offset[31:16]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // entries_held[4:0], zero[7:5]
   logic       rsp_tuser;         // is_duplicate[0]
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;   // ident_only_mode[0]

   dup_history_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycles = 0;

   recent_packet_duplicate_filter #(.HISTORY_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_served + 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata[4:0]);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [15:0] id, input logic [15:0] off);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {off, id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(id, off);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      sb.set_mode(m);
      csr_valid <= 1'b0;
   endtask

   task automatic fill_history();
      logic [31:0] k;
      while (!sb.offsets_ready()) begin
         k = $urandom;
         send_item(k[15:0], k[31:16]);
      end
   endtask

   task automatic run_phase(input int count, input logic m, input int tx_pct,
                            input int rx_pct, input pressure_e press);
      int r;
      logic [31:0] k;
      logic [15:0] id;
      logic [15:0] off;
      drain();
      write_mode(m);
      send_idle_pct = tx_pct;
      recv_idle_pct = rx_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) begin
            if (press == PRESS_RX_HOLD) hold_requests = hold_requests + 1;
            if (press == PRESS_TX_PAUSE) drain();
         end
         r = $urandom_range(99);
         if (r < 40 && sb.held > 0) begin
            // revisit a held key, sometimes with a fresh offset
            k = sb.held_key($urandom_range(sb.held - 1));
            id = k[15:0];
            off = ($urandom_range(3) == 0) ? 16'($urandom) : k[31:16];
         end else if (r < 60) begin
            id = 16'($urandom_range(7));
            off = 16'($urandom_range(3));
         end else begin
            k = $urandom;
            id = k[15:0];
            off = k[31:16];
         end
         send_item(id, off);
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(16'h0000, 16'h0000);
      send_item(16'h0000, 16'h0000);
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'h0000, 16'hFFFF);
      send_item(16'hFFFF, 16'h0000);
      send_item(16'h0000, 16'h0000);
      send_item(16'hA5A5, 16'h5A5A);
      send_item(16'h5A5A, 16'hA5A5);
      send_item(16'hA5A5, 16'h5A5A);
      // wrap the ring so every slot holds a known offset, evicting the oldest keys
      fill_history();
      send_item(16'h0000, 16'h0000);

      drain();
      write_mode(1'b1);
      send_item(16'hFFFF, 16'h1234);
      send_item(16'h1357, 16'h0000);
      send_item(16'h1357, 16'hFFFF);
      send_item(16'h2468, 16'hBEEF);
      send_item(16'h2468, 16'h0001);

      run_phase(600, 1'b0, 9, 70, PRESS_RX_HOLD);
      run_phase(600, 1'b1, 70, 9, PRESS_NONE);
      run_phase(550, 1'b0, 0, 0, PRESS_TX_PAUSE);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
